[src/esm_pkg.sv]
`default_nettype none

package esm_pkg;

    localparam int VALUE_W = 32;
    localparam int COL_W   = 11;
    localparam int MAT_W   = VALUE_W + COL_W;
    localparam int ACC_W   = 72;

    typedef enum logic [1:0] {
        KIND_WRITE_ENTRY  = 2'd0,
        KIND_WRITE_VECTOR = 2'd1,
        KIND_COMPUTE      = 2'd2,
        KIND_UNUSED       = 2'd3
    } esm_kind_t;

    typedef enum logic [1:0] {
        CFG_NUM_ROWS      = 2'd0,
        CFG_SLOTS_PER_ROW = 2'd1,
        CFG_INDEX_BASE    = 2'd2,
        CFG_NONE          = 2'd3
    } esm_cfg_index_t;

    typedef enum logic [1:0] {
        ESM_IDLE,
        ESM_ISSUE,
        ESM_WAIT,
        ESM_FINISH
    } esm_state_t;

    // One slot's operands as they leave the memory pipeline.
    typedef struct packed {
        logic               valid;
        logic               last;
        logic               bad;
        logic [VALUE_W-1:0] a;
        logic [VALUE_W-1:0] b;
    } esm_operand_t;

    // Row total after rounding and clipping.
    typedef struct packed {
        logic               done;
        logic               bad;
        logic               sat;
        logic [VALUE_W-1:0] value;
    } esm_mac_res_t;

endpackage

`default_nettype wire

[src/esm_in_if.sv]
`default_nettype none

interface esm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [9:0]  row;
    logic [4:0]  slot;
    logic [10:0] column;
    logic [31:0] value;
    logic        subtract;

    modport source (output valid, kind, row, slot, column, value, subtract, input ready);
    modport sink   (input valid, kind, row, slot, column, value, subtract, output ready);
endinterface

`default_nettype wire

[src/esm_out_if.sv]
`default_nettype none

interface esm_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  result_row;
    logic [31:0] result_value;
    logic        saturated;
    logic        bad_column;

    modport source (output valid, result_row, result_value, saturated, bad_column, input ready);
    modport sink   (input valid, result_row, result_value, saturated, bad_column, output ready);
endinterface

`default_nettype wire

[src/esm_store.sv]
`default_nettype none

module esm_store #(
    parameter int MAX_ROWS   = 1024,
    parameter int MAX_SLOTS  = 32,
    parameter int VECTOR_LEN = 1024,
    localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
    localparam int X_W       = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 mat_we,
    input  wire logic [ROW_W+SLOT_W-1:0]              mat_waddr,
    input  wire logic [esm_pkg::VALUE_W-1:0]          mat_wvalue,
    input  wire logic [esm_pkg::COL_W-1:0]            mat_wcol,
    input  wire logic                                 vec_we,
    input  wire logic [X_W-1:0]                       vec_waddr,
    input  wire logic [esm_pkg::VALUE_W-1:0]          vec_wdata,
    input  wire logic                                 rd_valid,
    input  wire logic                                 rd_last,
    input  wire logic [ROW_W+SLOT_W-1:0]              rd_addr,
    input  wire logic                                 index_base,
    output esm_pkg::esm_operand_t                     opnd
);

    localparam int MAT_DEPTH = MAX_ROWS * (2 ** SLOT_W);

    logic [esm_pkg::MAT_W-1:0]   mat_mem [MAT_DEPTH];
    logic [esm_pkg::VALUE_W-1:0] vec_mem [VECTOR_LEN];

    logic [esm_pkg::MAT_W-1:0]   mat_rd_reg;
    logic                        valid1_reg;
    logic                        last1_reg;

    logic [esm_pkg::VALUE_W-1:0] x_rd_reg;
    logic [esm_pkg::VALUE_W-1:0] a2_reg;
    logic                        bad2_reg;
    logic                        valid2_reg;
    logic                        last2_reg;

    logic [esm_pkg::COL_W-1:0]   stored_col;
    logic [esm_pkg::COL_W:0]     col_off;
    logic [31:0]                 col_off_ext;
    logic                        col_bad;
    logic [X_W-1:0]              x_addr;

    // Matrix memory: one row of slots per block of 2**SLOT_W entries.
    always_ff @(posedge clk)
    begin
        if (mat_we)
        begin
            mat_mem[mat_waddr] <= {mat_wvalue, mat_wcol};
        end
        mat_rd_reg <= mat_mem[rd_addr];
    end

    // A stored index below the base wraps negative and sets the top bit.
    assign stored_col  = mat_rd_reg[esm_pkg::COL_W-1:0];
    assign col_off     = {1'b0, stored_col} - (esm_pkg::COL_W+1)'(index_base);
    assign col_off_ext = 32'(col_off);
    assign col_bad     = col_off[esm_pkg::COL_W] || (col_off_ext >= 32'(VECTOR_LEN));
    assign x_addr      = col_off_ext[X_W-1:0];

    always_ff @(posedge clk)
    begin
        if (vec_we)
        begin
            vec_mem[vec_waddr] <= vec_wdata;
        end
        x_rd_reg <= vec_mem[x_addr];
        a2_reg   <= mat_rd_reg[esm_pkg::MAT_W-1:esm_pkg::COL_W];
        bad2_reg <= col_bad;
        last1_reg <= rd_last;
        last2_reg <= last1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= rd_valid;
            valid2_reg <= valid1_reg;
        end
    end

    assign opnd.valid = valid2_reg;
    assign opnd.last  = last2_reg;
    assign opnd.bad   = bad2_reg;
    assign opnd.a     = a2_reg;
    assign opnd.b     = x_rd_reg;

endmodule

`default_nettype wire

[src/esm_mac.sv]
`default_nettype none

module esm_mac (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic                        start_sub,
    input  wire logic [esm_pkg::VALUE_W-1:0] start_q,
    input  wire esm_pkg::esm_operand_t       opnd,
    output esm_pkg::esm_mac_res_t            res
);

    localparam int ACC_W = esm_pkg::ACC_W;

    logic signed [63:0]      prod_full;
    logic signed [63:0]      prod_reg;
    logic                    valid3_reg;
    logic                    last3_reg;
    logic                    bad3_reg;

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] prod_ext;
    logic                    sub_reg;
    logic                    bad_reg;
    logic                    bad_next;
    logic                    done_reg;

    logic [ACC_W-1:0]        rnd;
    logic                    sat_hi;
    logic                    sat_lo;

    assign prod_full = $signed(opnd.a) * $signed(opnd.b);

    // Product stage; a bad column contributes zero.
    always_ff @(posedge clk)
    begin
        prod_reg  <= opnd.bad ? 64'sd0 : prod_full;
        bad3_reg  <= opnd.bad;
        last3_reg <= opnd.last;
    end

    assign prod_ext = {{(ACC_W-64){prod_reg[63]}}, prod_reg};

    always_comb
    begin
        acc_next = acc_reg;
        bad_next = bad_reg;
        if (start)
        begin
            // q in Q16.16 is placed at Q32.32 alignment.
            acc_next = start_sub ? {{(ACC_W-48){start_q[31]}}, start_q, 16'd0} : '0;
            bad_next = 1'b0;
        end
        else if (valid3_reg)
        begin
            acc_next = sub_reg ? (acc_reg - prod_ext) : (acc_reg + prod_ext);
            bad_next = bad_reg | bad3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        bad_reg <= bad_next;
        if (start)
        begin
            sub_reg <= start_sub;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid3_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            valid3_reg <= opnd.valid;
            done_reg   <= valid3_reg && last3_reg;
        end
    end

    // Round half up at bit 15, then clip to the signed 32-bit range.
    assign rnd    = acc_reg + ACC_W'(32768);
    assign sat_hi = !rnd[ACC_W-1] && (|rnd[ACC_W-1:47]);
    assign sat_lo = rnd[ACC_W-1] && !(&rnd[ACC_W-1:47]);

    assign res.done  = done_reg;
    assign res.bad   = bad_reg;
    assign res.sat   = sat_hi || sat_lo;
    assign res.value = sat_hi ? 32'h7FFF_FFFF : (sat_lo ? 32'h8000_0000 : rnd[47:16]);

endmodule

`default_nettype wire

[src/ell_sparse_matvec.sv]
// Write words (matrix entry or vector element) leave no result.
// A compute word walks the row's slots from acceptance to its result word,
// where the slot count is the configured one clipped to MAX_SLOTS; one compute word
// is in work at a time, so the rate is set by the single read port walking the
// row's slots one per cycle through the matrix and vector memories.
// Reset clears control state and configuration; the memories are not cleared.
`default_nettype none

module ell_sparse_matvec #(
    parameter int MAX_ROWS   = 1024,
    parameter int MAX_SLOTS  = 32,
    parameter int VECTOR_LEN = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data,
    esm_in_if.sink           req,
    esm_out_if.source        rsp
);

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int X_W    = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;

    // Configuration registers.
    logic [10:0] num_rows_reg;
    logic [5:0]  slots_per_row_reg;
    logic        index_base_reg;

    // Control state.
    esm_pkg::esm_state_t state_reg;
    esm_pkg::esm_state_t state_next;
    logic [SLOT_W-1:0]   cnt_reg;
    logic [SLOT_W-1:0]   cnt_next;
    logic [6:0]          nslots_reg;
    logic [6:0]          nslots_next;
    logic [ROW_W-1:0]    row_idx_reg;
    logic [9:0]          row_field_reg;

    // Result word register.
    logic                out_valid_reg;
    logic [9:0]          out_row_reg;
    logic [31:0]         out_value_reg;
    logic                out_sat_reg;
    logic                out_bad_reg;

    logic                accept;
    logic                start;
    logic                row_ok;
    logic                issue_last;
    logic                rd_valid;
    logic                out_load;
    logic [31:0]         row_ext;
    logic [31:0]         slot_ext;
    logic [31:0]         col_ext;
    logic [6:0]          spr_clip;

    esm_pkg::esm_operand_t opnd;
    esm_pkg::esm_mac_res_t mac_res;

    // Configuration writes; indexes past the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg      <= 11'd1024;
            slots_per_row_reg <= 6'd32;
            index_base_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (esm_pkg::esm_cfg_index_t'(cfg_index))
                esm_pkg::CFG_NUM_ROWS:      num_rows_reg      <= cfg_data;
                esm_pkg::CFG_SLOTS_PER_ROW: slots_per_row_reg <= cfg_data[5:0];
                esm_pkg::CFG_INDEX_BASE:    index_base_reg    <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    // Words are taken only between compute items; writes land in the
    // memories at the accepting edge, so later reads always see them.
    assign req.ready = (state_reg == esm_pkg::ESM_IDLE);
    assign accept    = req.valid && req.ready;

    assign row_ext  = 32'(req.row);
    assign slot_ext = 32'(req.slot);
    assign col_ext  = 32'(req.column);

    // Rows outside the configured count or the store produce no result.
    assign row_ok = (row_ext < 32'(num_rows_reg)) && (row_ext < 32'(MAX_ROWS));
    assign start  = accept && (req.kind == esm_pkg::KIND_COMPUTE) && row_ok;

    // A slot count above the store depth acts as the store depth.
    assign spr_clip = (7'(slots_per_row_reg) < 7'(MAX_SLOTS)) ? 7'(slots_per_row_reg)
                                                                : 7'(MAX_SLOTS);

    assign issue_last = (7'(cnt_reg) + 7'd1) == nslots_reg;
    assign rd_valid   = (state_reg == esm_pkg::ESM_ISSUE);
    assign out_load   = (state_reg == esm_pkg::ESM_FINISH) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        nslots_next = nslots_reg;
        case (state_reg)
            esm_pkg::ESM_IDLE:
            begin
                if (start)
                begin
                    cnt_next    = '0;
                    nslots_next = spr_clip;
                    // With no slots the result is just the starting value.
                    state_next  = (spr_clip == 7'd0) ? esm_pkg::ESM_FINISH
                                                     : esm_pkg::ESM_ISSUE;
                end
            end
            esm_pkg::ESM_ISSUE:
            begin
                cnt_next = cnt_reg + SLOT_W'(1);
                if (issue_last)
                begin
                    state_next = esm_pkg::ESM_WAIT;
                end
            end
            esm_pkg::ESM_WAIT:
            begin
                if (mac_res.done)
                begin
                    state_next = esm_pkg::ESM_FINISH;
                end
            end
            esm_pkg::ESM_FINISH:
            begin
                if (out_load)
                begin
                    state_next = esm_pkg::ESM_IDLE;
                end
            end
            default:
            begin
                state_next = esm_pkg::ESM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= esm_pkg::ESM_IDLE;
            cnt_reg    <= '0;
            nslots_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            nslots_reg <= nslots_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            row_idx_reg   <= row_ext[ROW_W-1:0];
            row_field_reg <= req.row;
        end
    end

    esm_store #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_SLOTS  (MAX_SLOTS),
        .VECTOR_LEN (VECTOR_LEN)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .mat_we     (accept && (req.kind == esm_pkg::KIND_WRITE_ENTRY)
                     && (row_ext < 32'(MAX_ROWS)) && (slot_ext < 32'(MAX_SLOTS))),
        .mat_waddr  ({row_ext[ROW_W-1:0], slot_ext[SLOT_W-1:0]}),
        .mat_wvalue (req.value),
        .mat_wcol   (req.column),
        .vec_we     (accept && (req.kind == esm_pkg::KIND_WRITE_VECTOR)
                     && (col_ext < 32'(VECTOR_LEN))),
        .vec_waddr  (col_ext[X_W-1:0]),
        .vec_wdata  (req.value),
        .rd_valid   (rd_valid),
        .rd_last    (issue_last),
        .rd_addr    ({row_idx_reg, cnt_reg}),
        .index_base (index_base_reg),
        .opnd       (opnd)
    );

    esm_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .start_sub (req.subtract),
        .start_q   (req.value),
        .opnd      (opnd),
        .res       (mac_res)
    );

    // Output register: a finished row waits here while the next word is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_row_reg   <= row_field_reg;
            out_value_reg <= mac_res.value;
            out_sat_reg   <= mac_res.sat;
            out_bad_reg   <= mac_res.bad;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_row   = out_row_reg;
    assign rsp.result_value = out_value_reg;
    assign rsp.saturated    = out_sat_reg;
    assign rsp.bad_column   = out_bad_reg;

    // A started row always leads to slot issue or straight to finishing.
    a_start_moves: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (state_reg == esm_pkg::ESM_ISSUE) || (state_reg == esm_pkg::ESM_FINISH))
        else $error("compute start did not leave idle");

    // The row walk never runs past the configured slot count.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == esm_pkg::ESM_ISSUE) |-> (7'(cnt_reg) < nslots_reg))
        else $error("slot counter beyond slot count");

    // Operands only leave the memory pipeline while a row is being worked.
    a_opnd_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        opnd.valid |-> (state_reg == esm_pkg::ESM_ISSUE) || (state_reg == esm_pkg::ESM_WAIT))
        else $error("operand outside a row walk");

    // The accumulator reports completion only while the controller waits for it.
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mac_res.done |-> (state_reg == esm_pkg::ESM_WAIT))
        else $error("accumulator done outside wait");

endmodule

`default_nettype wire
